FILE: hw/rtl/fnvm_pkg.sv
// Package: constants, item type and hash functions for the FNV-1a hash with closing mix.
`timescale 1ns / 1ps
`default_nettype none

package fnvm_pkg;

    localparam int unsigned HASH_W = 64;
    localparam int unsigned BYTE_W = 8;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 64'd16777619;

    // Shift amounts of the closing mix, applied in this order.
    localparam int unsigned MIX_ADD_A = 13;
    localparam int unsigned MIX_XOR_A = 7;
    localparam int unsigned MIX_ADD_B = 3;
    localparam int unsigned MIX_XOR_B = 17;
    localparam int unsigned MIX_ADD_C = 5;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              byte_valid;
        logic              last;
    } item_t;

    // h * 0x0100_0193 mod 2^64 as shift-add: 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1
    function automatic logic [HASH_W-1:0] mul_prime(input logic [HASH_W-1:0] h);
        mul_prime = (h << 24) + (h << 8) + (h << 7) + (h << 4) + (h << 1) + h;
    endfunction

    function automatic logic [HASH_W-1:0] finish_mix(input logic [HASH_W-1:0] h_in);
        logic [HASH_W-1:0] h;
        h = h_in;
        h = h + (h << MIX_ADD_A);
        h = h ^ (h >> MIX_XOR_A);
        h = h + (h << MIX_ADD_B);
        h = h ^ (h >> MIX_XOR_B);
        h = h + (h << MIX_ADD_C);
        finish_mix = h;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/byte_stream_fnv_hash_with_mix.sv
// Top level: streaming FNV-1a byte hash with closing avalanche mix.
// Usage:
//   Input channel (s_valid/s_ready) carries one message byte per item with
//   s_byte_valid (byte belongs to the message) and s_last (end of message).
//   An item with s_last set may carry no byte (s_byte_valid low).
//   Output channel (m_valid/m_ready) carries one 64-bit hash per message.
// Throughput: one item per cycle, sustained, as long as m_ready keeps up;
//   every byte is absorbed in the cycle it is accepted (shift-add multiply).
// Result path: the finish register takes the unmixed hash at the edge that
//   accepts the last item; the mix lands in the output register, with m_valid,
//   at the first later edge at which the output register is free or draining.
// Stall: while m_ready is low the output holds; the finish register still
//   takes one more last item, and s_ready drops only when both are full.
//   Until then non-last items keep flowing; once both are full every item
//   waits for m_ready.
// Reset (aresetn low, synchronous): running hash reloads the offset basis,
//   both result stages empty. After each message the hash reloads as well.
`timescale 1ns / 1ps
`default_nettype none

module byte_stream_fnv_hash_with_mix #(
    parameter logic [fnvm_pkg::HASH_W-1:0] BASIS = fnvm_pkg::FNV_BASIS
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [fnvm_pkg::BYTE_W-1:0]  s_data_byte,
    input  wire                          s_byte_valid,
    input  wire                          s_last,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [fnvm_pkg::HASH_W-1:0]  m_hash_value
);

    fnvm_pkg::item_t             in_item;
    logic                        in_accept;
    logic                        fin_valid;
    logic [fnvm_pkg::HASH_W-1:0] fin_hash;
    logic                        out_free;
    logic                        fin_take;
    logic                        fin_free;

    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [fnvm_pkg::HASH_W-1:0] m_hash_reg;

    assign in_item.data_byte  = s_data_byte;
    assign in_item.byte_valid = s_byte_valid;
    assign in_item.last       = s_last;

    // pipeline backpressure: output frees the finish slot, finish slot frees the input
    assign out_free  = !m_valid_reg || m_ready;
    assign fin_take  = fin_valid && out_free;
    assign fin_free  = !fin_valid || fin_take;
    assign s_ready   = fin_free;
    assign in_accept = s_valid && s_ready;

    fnvm_core #(
        .BASIS (BASIS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_item   (in_item),
        .fin_take  (fin_take),
        .fin_valid (fin_valid),
        .fin_hash  (fin_hash)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = fin_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (fin_take) begin
            m_hash_reg <= fnvm_pkg::finish_mix(fin_hash);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;

    // accepted last item always lands in the finish register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_last) |=> fin_valid)
        else $error("last item not captured in finish stage");

    // finish register holds its hash while the output is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_valid && !out_free) |=> (fin_valid && $stable(fin_hash)))
        else $error("finish stage lost or changed while stalled");

    // a new result only ever comes out of a full finish register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && m_valid_next) |-> fin_valid)
        else $error("result appeared without a finished message");

    // input stalls only when both result stages are occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (fin_valid && m_valid_reg && !m_ready))
        else $error("input stalled with room in the result stages");

endmodule

`default_nettype wire

FILE: hw/rtl/fnvm_core.sv
// Running FNV-1a accumulator and the register that holds a finished message hash.
`timescale 1ns / 1ps
`default_nettype none

module fnvm_core #(
    parameter logic [fnvm_pkg::HASH_W-1:0] BASIS = fnvm_pkg::FNV_BASIS
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          in_accept,
    input  wire fnvm_pkg::item_t         in_item,
    input  wire                          fin_take,
    output logic                         fin_valid,
    output logic [fnvm_pkg::HASH_W-1:0]  fin_hash
);

    logic [fnvm_pkg::HASH_W-1:0] running_reg;
    logic [fnvm_pkg::HASH_W-1:0] running_next;
    logic [fnvm_pkg::HASH_W-1:0] absorbed;
    logic                        fin_valid_reg;
    logic                        fin_valid_next;
    logic [fnvm_pkg::HASH_W-1:0] fin_hash_reg;

    always_comb begin
        absorbed = running_reg;
        if (in_item.byte_valid) begin
            absorbed = fnvm_pkg::mul_prime(
                running_reg ^ {{(fnvm_pkg::HASH_W-fnvm_pkg::BYTE_W){1'b0}}, in_item.data_byte});
        end
        running_next = running_reg;
        if (in_accept) begin
            running_next = in_item.last ? BASIS : absorbed;
        end
        // caller accepts a last item only when the finish slot is free or draining
        fin_valid_next = fin_valid_reg && !fin_take;
        if (in_accept && in_item.last) begin
            fin_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg   <= BASIS;
            fin_valid_reg <= 1'b0;
        end else begin
            running_reg   <= running_next;
            fin_valid_reg <= fin_valid_next;
        end
        if (in_accept && in_item.last) begin
            fin_hash_reg <= absorbed;
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin_hash  = fin_hash_reg;

endmodule

`default_nettype wire

FILE: dv/tb_byte_stream_fnv_hash_with_mix.sv
// Testbench for the streaming FNV-1a byte hash with closing mix: directed, random and stall tests.
`timescale 1ns / 1ps

module tb_byte_stream_fnv_hash_with_mix;

    localparam int unsigned HW = fnvm_pkg::HASH_W;
    localparam int unsigned BW = fnvm_pkg::BYTE_W;

    // Watchdog: cycles with no item moving on either channel.
    localparam int unsigned STALL_LIMIT = 2000;
    // Receiver hold-off for the backpressure test; well under STALL_LIMIT.
    localparam int unsigned HOLD_OFF    = 300;
    // Quiet cycles at the end.
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned MAX_REPORTS = 10;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    logic [BW-1:0] s_data_byte;
    logic          s_byte_valid;
    logic          s_last;
    logic          m_valid;
    logic          m_ready;
    logic [HW-1:0] m_hash_value;

    byte_stream_fnv_hash_with_mix u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_byte_valid (s_byte_valid),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    // Predictor state: running hash as the block should hold it, and the
    // mixed hashes of finished messages still waiting on the output channel.
    logic [HW-1:0] run_hash;
    logic [HW-1:0] pending_hashes[$];

    int unsigned   err_count   = 0;
    int unsigned   msgs_sent   = 0;   // last items accepted
    int unsigned   hashes_seen = 0;   // hashes accepted on the output
    int unsigned   quiet_count = 0;
    int unsigned   hold_cycles = 0;   // receiver hold-off request
    bit            src_idle_en = 1'b1;
    bit            snk_idle_en = 1'b1;

    // Clock: 2 ns period.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Hash predictor
    // ------------------------------------------------------------------

    // One FNV-1a step: fold the byte in, multiply by the prime mod 2^64.
    function automatic logic [HW-1:0] fnv_absorb(logic [HW-1:0] h, logic [BW-1:0] b);
        return (h ^ {{(HW-BW){1'b0}}, b}) * fnvm_pkg::FNV_PRIME;
    endfunction

    // Closing avalanche: add-shift, xor-shift, add-shift, xor-shift, add-shift.
    function automatic logic [HW-1:0] fnv_finish(logic [HW-1:0] h_in);
        logic [HW-1:0] h;
        h = h_in;
        h = h + (h << fnvm_pkg::MIX_ADD_A);
        h = h ^ (h >> fnvm_pkg::MIX_XOR_A);
        h = h + (h << fnvm_pkg::MIX_ADD_B);
        h = h ^ (h >> fnvm_pkg::MIX_XOR_B);
        h = h + (h << fnvm_pkg::MIX_ADD_C);
        return h;
    endfunction

    // Both channels are sampled at the rising edge, before any of this
    // edge's updates land. The input side is handled first so a hash is
    // always queued before it could possibly show up on the output.
    always @(posedge aclk) begin
        if (!aresetn) begin
            run_hash = fnvm_pkg::FNV_BASIS;
        end else begin
            if (s_valid && s_ready) begin
                // Byte is only absorbed when flagged; data is don't-care otherwise.
                if (s_byte_valid) begin
                    run_hash = fnv_absorb(run_hash, s_data_byte);
                end
                // Last item closes the message, even without a byte
                // (empty message mixes the bare offset basis).
                if (s_last) begin
                    pending_hashes.push_back(fnv_finish(run_hash));
                    run_hash = fnvm_pkg::FNV_BASIS;
                end
            end
            if (m_valid && m_ready) begin
                hashes_seen++;
                if (pending_hashes.size() == 0) begin
                    if (err_count < MAX_REPORTS) begin
                        $display("unexpected hash %h at %0t", m_hash_value, $realtime);
                    end
                    err_count++;
                end else if (m_hash_value !== pending_hashes[0]) begin
                    if (err_count < MAX_REPORTS) begin
                        $display("hash mismatch: expected %h got %h at %0t",
                                 pending_hashes[0], m_hash_value, $realtime);
                    end
                    err_count++;
                    void'(pending_hashes.pop_front());
                end else begin
                    void'(pending_hashes.pop_front());
                end
            end
        end
    end

    // Watchdog: ends the run if nothing moves for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_count <= 0;
            end else if (quiet_count >= STALL_LIMIT) begin
                $display("timeout: no item accepted for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                quiet_count <= quiet_count + 1;
            end
        end
    end

    // Receiver: random idling, plus a counted hold-off when a test asks.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                m_ready <= !(snk_idle_en && ($urandom_range(99) < 21));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one item and hold it until accepted. A random gap before it
    // drops valid and drives junk on the payload, which must be ignored.
    task automatic send_item(input logic [BW-1:0] data, input logic has_byte,
                             input logic is_last);
        int unsigned gap;
        gap = 0;
        if (src_idle_en && ($urandom_range(99) < 21)) begin
            gap = $urandom_range(1, 5);
        end
        if (gap != 0) begin
            s_valid      <= 1'b0;
            s_data_byte  <= BW'($urandom_range(255));
            s_byte_valid <= 1'($urandom_range(1));
            s_last       <= 1'($urandom_range(1));
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= data;
        s_byte_valid <= has_byte;
        s_last       <= is_last;
        do @(posedge aclk); while (!s_ready);
        if (is_last) begin
            msgs_sent++;
        end
    endtask

    // Idle the input and wait until every finished message's hash has come out.
    task automatic drain_hashes();
        s_valid <= 1'b0;
        do @(posedge aclk); while (hashes_seen < msgs_sent);
    endtask

    // Random message: body of random bytes with stray ignored items mixed
    // in, closed by a last item that may or may not carry a byte.
    // Returns the number of counted items (ignored ones excluded).
    task automatic send_message(input int unsigned body_len, output int unsigned n_items);
        n_items = 0;
        for (int unsigned i = 0; i < body_len; i++) begin
            if ($urandom_range(99) < 10) begin
                send_item(BW'($urandom_range(255)), 1'b0, 1'b0);
            end
            send_item(BW'($urandom_range(255)), 1'b1, 1'b0);
            n_items++;
        end
        send_item(BW'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        n_items++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes and the special cases, one message at a time.
    task automatic test_directed();
        // Empty message, twice in a row; second one carries a dead byte.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
        // Single-byte messages at both byte extremes.
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        // Items that are neither byte nor last are ignored entirely.
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);
        // Message closed by a last item without a byte.
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'hFE, 1'b1, 1'b0);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'hAA, 1'b1, 1'b0);
        send_item(8'h33, 1'b0, 1'b1);
        // Invalid byte in the middle of a message.
        send_item(8'h10, 1'b1, 1'b0);
        send_item(8'hC3, 1'b0, 1'b0);
        send_item(8'h20, 1'b1, 1'b1);
        // All-ones message.
        repeat (6) send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        drain_hashes();
    endtask

    // Bulk random messages, mostly short with an occasional long one.
    task automatic test_random_messages(input int unsigned n_target);
        int unsigned done;
        int unsigned n;
        int unsigned body_len;
        done = 0;
        while (done < n_target) begin
            if ($urandom_range(99) < 10) begin
                body_len = $urandom_range(16, 40);
            end else begin
                body_len = $urandom_range(0, 8);
            end
            send_message(body_len, n);
            done += n;
        end
        drain_hashes();
    endtask

    // Full rate on both sides: no idling anywhere for the whole stretch.
    task automatic test_back_to_back(input int unsigned n_target);
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        test_random_messages(n_target);
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    // Receiver holds off while short messages keep coming, so both result
    // stages fill and s_ready has to drop until the output drains.
    task automatic test_output_stall(input int unsigned n_msgs);
        int unsigned n;
        hold_cycles = HOLD_OFF;
        for (int unsigned i = 0; i < n_msgs; i++) begin
            send_message($urandom_range(0, 2), n);
        end
        drain_hashes();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_data_byte  <= '0;
        s_byte_valid <= 1'b0;
        s_last       <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_messages(300);
        test_back_to_back(80);
        test_output_stall(40);

        repeat (SETTLE) @(posedge aclk);
        if (pending_hashes.size() != 0) begin
            $display("%0d hashes never arrived", pending_hashes.size());
            err_count += pending_hashes.size();
        end
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
